// ===== hw/rtl/fdl_pkg.sv =====
// Package for the fractional delay line: sequencer states, register indexes
// and fixed-point constants. No dependencies.
package fdl_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Register field widths
  localparam int unsigned DELAY_W = 12;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned GAIN_W  = 17;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET        = 3'd5;

  // Mode codes
  localparam logic MODE_FEEDBACK = 1'b0;
  localparam logic MODE_ALLPASS  = 1'b1;

  // Q1.16 constants
  localparam logic [GAIN_W-1:0] Q16_ONE  = 17'h10000;
  localparam logic [GAIN_W-1:0] Q16_HALF = 17'h08000;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_FRAC,
    S_TAP,
    S_MUL_A,
    S_STORE,
    S_MUL_B,
    S_FIN_B,
    S_MUL_C,
    S_MUL_D,
    S_MIX
  } fdl_state_e;

endpackage

// ===== hw/rtl/fractional_delay_line_with_feedback.sv =====
// Fractional delay line with feedback or allpass mode, top level.
// Holds the delay store, the shared multiplier and its sequencer; uses fdl_pkg.
//
// One signed sample beat in gives one processed sample beat out. The block
// takes a beat only when its sequencer is idle; one item occupies it from
// the accept edge to the edge that loads the output register, in feedback
// mode through more steps than in allpass mode, so no new beat is taken
// before the last one is through in either mode. That pacing is set by the
// single shared 18-bit-coefficient multiplier, which serves four products in
// feedback mode (interpolation, feedback, decay, two-term mix accumulated)
// and three in allpass mode, each followed by a rounding/saturation step.
// Both delay taps are read from the store in the accept cycle on two read
// ports. The store needs no clearing pass after reset: a fill count marks the
// written prefix of the ring and slots beyond it read as zero, so the block
// is ready right after reset. A finished result waits in the output register;
// a new beat is accepted meanwhile and the sequencer stalls in its last step
// only if the previous result is still not taken. Configuration may be
// written only while the block is idle.
module fractional_delay_line_with_feedback #(
  parameter int unsigned CAPACITY    = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // input sample channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in_i,
  // output sample channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_out_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned DW  = (AW > fdl_pkg::DELAY_W) ? AW : fdl_pkg::DELAY_W;
  localparam int unsigned MBW = fdl_pkg::GAIN_W + 1;   // signed coefficient operand
  localparam int unsigned PW  = SB + 1 + MBW;          // raw product
  localparam int unsigned PRW = PW + 1;                // accumulated product
  localparam int unsigned RW  = PRW - 16;              // after Q0.16 rounding
  localparam int unsigned SW  = RW + 1;                // headroom for one more add

  localparam logic [DW-1:0] DMAX = DW'(CAPACITY - 1);
  localparam logic signed [SW-1:0] SMAX = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  // floor((p + 32768) / 65536)
  function automatic logic signed [RW-1:0] rnd_q16(input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] t;
    t = p + $signed(PRW'(fdl_pkg::Q16_HALF));
    return t[PRW-1:16];
  endfunction

  // clip to the signed sample range
  function automatic logic signed [SB-1:0] sat_s(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return c[SB-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                              mode_q;
  logic [fdl_pkg::DELAY_W-1:0]       delay_q;
  logic [fdl_pkg::FRAC_W-1:0]        frac_q;
  logic [fdl_pkg::GAIN_W-1:0]        fb_gain_q;
  logic [fdl_pkg::GAIN_W-1:0]        decay_q;
  logic [fdl_pkg::GAIN_W-1:0]        wet_q_cfg;

  // decode and take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= fdl_pkg::MODE_FEEDBACK;
      delay_q   <= '0;
      frac_q    <= '0;
      fb_gain_q <= '0;
      decay_q   <= fdl_pkg::Q16_ONE;
      wet_q_cfg <= fdl_pkg::Q16_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fdl_pkg::REG_MODE:     mode_q    <= cfg_wdata_i[0];
        fdl_pkg::REG_DELAY:    delay_q   <= cfg_wdata_i[fdl_pkg::DELAY_W-1:0];
        fdl_pkg::REG_FRACTION: frac_q    <= cfg_wdata_i[fdl_pkg::FRAC_W-1:0];
        fdl_pkg::REG_FEEDBACK: fb_gain_q <= cfg_wdata_i[fdl_pkg::GAIN_W-1:0];
        fdl_pkg::REG_DECAY:    decay_q   <= cfg_wdata_i[fdl_pkg::GAIN_W-1:0];
        fdl_pkg::REG_WET:      wet_q_cfg <= cfg_wdata_i[fdl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Ring addressing at accept time
  // ---------------------------------------------------------------------
  fdl_pkg::fdl_state_e state_q, state_d;
  logic [AW-1:0]       wslot_q;
  logic [AW:0]         fill_q;
  logic [DW-1:0]       dly_ext;
  logic [DW-1:0]       dly_clip;
  logic [AW-1:0]       dly_c;
  logic [AW-1:0]       w_c;
  logic [AW-1:0]       rd_c;
  logic                in_fire;

  assign in_ready_o = (state_q == fdl_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // clamp the delay, fold a stale write slot, find the delay-D slot
  always_comb begin
    dly_ext  = DW'(delay_q);
    dly_clip = (dly_ext > DMAX) ? DMAX : dly_ext;
    dly_c    = dly_clip[AW-1:0];
    w_c      = (wslot_q > dly_c) ? '0 : wslot_q;
    rd_c     = (w_c >= dly_c) ? '0 : w_c + AW'(1);
  end

  // ---------------------------------------------------------------------
  // Delay store: two read ports at accept, one write port
  // ---------------------------------------------------------------------
  logic signed [SB-1:0] line_mem [CAPACITY];
  logic signed [SB-1:0] rd0_q, rd1_q;
  logic [AW-1:0]        w_q;
  logic                 mem_we;
  logic signed [SB-1:0] mem_wdata;
  logic signed [SB-1:0] store_val;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd0_q <= line_mem[rd_c];
      rd1_q <= line_mem[w_c];
    end
    if (mem_we) begin
      line_mem[w_q] <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Item payload registers
  // ---------------------------------------------------------------------
  logic signed [SB-1:0]  x_q;
  logic [AW-1:0]         nxt_q;
  logic                  dzero_q;
  logic                  v0_q, v1_q;
  logic signed [SB-1:0]  tap_q;
  logic signed [SB-1:0]  b_q;
  logic signed [SB-1:0]  wet_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [SB-1:0]  out_q;
  logic                  out_valid_q;

  // control signals from the sequencer
  logic                  mul_en, tap_en, store_en, wet_en, out_load;
  logic signed [SB-1:0]  res_d;

  // ---------------------------------------------------------------------
  // Shared multiplier with accumulate input
  // ---------------------------------------------------------------------
  logic signed [SB-1:0]  s0, s1;
  logic signed [SB:0]    mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [PRW-1:0] acc_in;
  logic signed [PRW-1:0] prod_d;
  logic [fdl_pkg::GAIN_W-1:0] ws_c;
  logic signed [RW-1:0]  rnd_c;

  // taps: fresh input at zero delay, zero beyond the written prefix
  always_comb begin
    s0 = dzero_q ? x_q : (v0_q ? rd0_q : '0);
    s1 = dzero_q ? x_q : (v1_q ? rd1_q : '0);
    ws_c = (wet_q_cfg > fdl_pkg::Q16_ONE) ? fdl_pkg::Q16_ONE : wet_q_cfg;
    rnd_c = rnd_q16(prod_q);
  end

  // select operands per step
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    acc_in = '0;
    case (state_q)
      fdl_pkg::S_MUL_FRAC: begin
        mul_a = (SB+1)'(s1) - (SB+1)'(s0);
        mul_b = $signed(MBW'(frac_q));
      end
      fdl_pkg::S_MUL_A: begin
        mul_a = (SB+1)'(tap_q);
        mul_b = $signed(MBW'((mode_q == fdl_pkg::MODE_ALLPASS) ? decay_q : fb_gain_q));
      end
      fdl_pkg::S_MUL_B: begin
        mul_a = (mode_q == fdl_pkg::MODE_ALLPASS) ? (SB+1)'(b_q) : (SB+1)'(tap_q);
        mul_b = $signed(MBW'(decay_q));
      end
      fdl_pkg::S_MUL_C: begin
        mul_a = (SB+1)'(x_q);
        mul_b = $signed(MBW'(fdl_pkg::Q16_ONE - ws_c));
      end
      fdl_pkg::S_MUL_D: begin
        mul_a  = (SB+1)'(wet_q);
        mul_b  = $signed(MBW'(ws_c));
        acc_in = prod_q;
      end
      default: ;
    endcase
    mul_p  = PW'(mul_a) * PW'(mul_b);
    prod_d = acc_in + PRW'(mul_p);
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_en    = 1'b0;
    tap_en    = 1'b0;
    store_en  = 1'b0;
    wet_en    = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    res_d     = '0;
    store_val = '0;
    unique case (state_q)
      fdl_pkg::S_IDLE: begin
        if (in_fire) state_d = fdl_pkg::S_MUL_FRAC;
      end
      fdl_pkg::S_MUL_FRAC: begin
        mul_en  = 1'b1;
        state_d = fdl_pkg::S_TAP;
      end
      fdl_pkg::S_TAP: begin
        tap_en  = 1'b1;
        state_d = fdl_pkg::S_MUL_A;
      end
      fdl_pkg::S_MUL_A: begin
        mul_en  = 1'b1;
        state_d = fdl_pkg::S_STORE;
      end
      fdl_pkg::S_STORE: begin
        // feedback stores x + tap*fb, allpass stores B = x - g*tap
        if (mode_q == fdl_pkg::MODE_ALLPASS) begin
          store_val = sat_s(SW'(x_q) - SW'(rnd_c));
        end else begin
          store_val = sat_s(SW'(x_q) + SW'(rnd_c));
        end
        // at zero delay the single slot keeps the raw input
        mem_wdata = dzero_q ? x_q : store_val;
        store_en  = 1'b1;
        mem_we    = 1'b1;
        state_d   = fdl_pkg::S_MUL_B;
      end
      fdl_pkg::S_MUL_B: begin
        mul_en  = 1'b1;
        state_d = fdl_pkg::S_FIN_B;
      end
      fdl_pkg::S_FIN_B: begin
        if (mode_q == fdl_pkg::MODE_ALLPASS) begin
          res_d = sat_s(SW'(tap_q) + SW'(rnd_c));
          if (!out_valid_q || out_ready_i) begin
            out_load = 1'b1;
            state_d  = fdl_pkg::S_IDLE;
          end
        end else begin
          wet_en  = 1'b1;
          state_d = fdl_pkg::S_MUL_C;
        end
      end
      fdl_pkg::S_MUL_C: begin
        mul_en  = 1'b1;
        state_d = fdl_pkg::S_MUL_D;
      end
      fdl_pkg::S_MUL_D: begin
        mul_en  = 1'b1;
        state_d = fdl_pkg::S_MIX;
      end
      fdl_pkg::S_MIX: begin
        res_d = sat_s(SW'(rnd_c));
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fdl_pkg::S_IDLE;
        end
      end
      default: state_d = fdl_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    // latch the beat and its ring slots
    if (in_fire) begin
      x_q     <= sample_in_i;
      w_q     <= w_c;
      nxt_q   <= rd_c;
      dzero_q <= (dly_c == '0);
      v0_q    <= ((AW+1)'(rd_c) < fill_q);
      v1_q    <= ((AW+1)'(w_c) < fill_q);
    end
    if (mul_en) prod_q <= prod_d;
    // interpolated tap stays between the two slots, so no clipping
    if (tap_en) tap_q <= SB'(SW'(s0) + SW'(rnd_c));
    if (store_en) b_q <= store_val;
    if (wet_en) wet_q <= sat_s(SW'(rnd_c));
    if (out_load) out_q <= res_d;
  end

  // advance the write slot and the written prefix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q <= '0;
      fill_q  <= '0;
    end else if (store_en) begin
      wslot_q <= nxt_q;
      if (mem_we && ((AW+1)'(w_q) >= fill_q)) begin
        fill_q <= (AW+1)'(w_q) + (AW+1)'(1);
      end
    end
  end

  // hold the result until the downstream takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // the written prefix never exceeds the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (AW+1)'(CAPACITY))
    else $error("fill count beyond store");

  // writes land inside the written prefix or right after it
  a_write_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((AW+1)'(w_q) <= fill_q))
    else $error("store write outside ring");

  // a result only appears from a finishing step
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == fdl_pkg::S_MIX ||
                            $past(state_q) == fdl_pkg::S_FIN_B))
    else $error("result loaded outside a finishing step");

  // an accepted beat starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == fdl_pkg::S_MUL_FRAC))
    else $error("sequencer did not start on accept");

  // a result is never overwritten while still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load |-> (!out_valid_q || out_ready_i)))
    else $error("pending result overwritten");

endmodule

// ===== verif/fractional_delay_line_with_feedback_tb.sv =====
// Self-checking testbench for the fractional delay line with feedback / allpass modes.
// Holds a sample predictor with its own delay store and a small output scoreboard;
// depends on fdl_pkg and fractional_delay_line_with_feedback.
`timescale 1ns / 100ps

module fractional_delay_line_with_feedback_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int CAP            = 4096;
  localparam int SAMPLE_W       = 16;
  localparam int LATENCY        = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 1680;

  // indexes that decode to no register
  localparam logic [fdl_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [fdl_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef logic signed [SAMPLE_W-1:0]     sample_t;
  typedef logic [fdl_pkg::CFG_DATA_W-1:0] cfg_word_t;

  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // Predicts processed samples from accepted input beats and grades output beats
  class fdl_echo_ledger;
    logic                        mode_q;
    logic [fdl_pkg::DELAY_W-1:0] delay_q;
    logic [fdl_pkg::FRAC_W-1:0]  frac_q;
    logic [fdl_pkg::GAIN_W-1:0]  feedback_q;
    logic [fdl_pkg::GAIN_W-1:0]  decay_q;
    logic [fdl_pkg::GAIN_W-1:0]  wet_q;
    sample_t                     line_q [CAP];
    int unsigned                 slot_q;
    sample_t                     echo_due [$];
    int unsigned                 faults;
    int unsigned                 beats;
    int unsigned                 allpass_beats;

    function new();
      foreach (line_q[i]) line_q[i] = '0;
      slot_q        = 0;
      mode_q        = fdl_pkg::MODE_FEEDBACK;
      delay_q       = '0;
      frac_q        = '0;
      feedback_q    = '0;
      decay_q       = fdl_pkg::Q16_ONE;
      wet_q         = fdl_pkg::Q16_ONE;
      faults        = 0;
      beats         = 0;
      allpass_beats = 0;
    endfunction

    static function longint clip_sample(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // floor((p + half) / one), arithmetic shift keeps the floor for negatives
    static function longint q16_round(longint p);
      return (p + 32768) >>> 16;
    endfunction

    function int unsigned pending();
      return echo_due.size();
    endfunction

    function void set_reg(logic [fdl_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
      case (idx)
        fdl_pkg::REG_MODE:     mode_q     = data[0];
        fdl_pkg::REG_DELAY:    delay_q    = data[fdl_pkg::DELAY_W-1:0];
        fdl_pkg::REG_FRACTION: frac_q     = data[fdl_pkg::FRAC_W-1:0];
        fdl_pkg::REG_FEEDBACK: feedback_q = data[fdl_pkg::GAIN_W-1:0];
        fdl_pkg::REG_DECAY:    decay_q    = data[fdl_pkg::GAIN_W-1:0];
        fdl_pkg::REG_WET:      wet_q      = data[fdl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void log_sample(sample_t x);
      longint      xs, s0, s1, tap, wet, ws, b, res;
      int unsigned d, w, rd, prev;
      xs = longint'(x);
      d  = 32'(delay_q);
      if (d > CAP - 1) d = CAP - 1;
      // a slot left over from a longer ring restarts at zero
      w = slot_q;
      if (w > d) w = 0;
      prev = w;
      rd   = (w >= d) ? 0 : w + 1;
      // zero delay: the single slot holds the fresh input
      if (d == 0) begin
        line_q[w] = x;
        rd = w;
      end
      s0  = longint'(line_q[rd]);
      s1  = longint'(line_q[prev]);
      tap = s0 + q16_round((s1 - s0) * longint'(frac_q));
      if (mode_q == fdl_pkg::MODE_FEEDBACK) begin
        if (d > 0) line_q[w] = sample_t'(clip_sample(xs + q16_round(tap * longint'(feedback_q))));
        wet = clip_sample(q16_round(tap * longint'(decay_q)));
        ws  = (wet_q > fdl_pkg::Q16_ONE) ? longint'(fdl_pkg::Q16_ONE) : longint'(wet_q);
        res = clip_sample(q16_round(xs * (longint'(fdl_pkg::Q16_ONE) - ws) + wet * ws));
      end else begin
        b = clip_sample(xs - q16_round(tap * longint'(decay_q)));
        if (d > 0) line_q[w] = sample_t'(b);
        res = clip_sample(tap + q16_round(b * longint'(decay_q)));
        allpass_beats++;
      end
      slot_q = (w >= d) ? 0 : w + 1;
      echo_due.push_back(sample_t'(res));
      beats++;
    endfunction

    function void grade_sample(sample_t got);
      sample_t want;
      if (echo_due.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, actual %0d", $time, got);
        faults++;
        return;
      end
      want = echo_due.pop_front();
      if (got !== want) begin
        $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
        faults++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_idx;
  cfg_word_t                     cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  sample_t                       sample_in;
  logic                          out_valid;
  logic                          out_ready;
  sample_t                       sample_out;

  fdl_echo_ledger ledger;
  bit             steady;
  bit             hold_req;
  int unsigned    holds_done;
  int unsigned    quiet_cycles;
  int unsigned    settings_used;
  int unsigned    widest_delay;

  fractional_delay_line_with_feedback #(
    .CAPACITY   (CAP),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_in_i (sample_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Grade output beats, predict input beats, and watch for a stuck handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) ledger.grade_sample(sample_out);
      if (in_valid && in_ready) ledger.log_sample(sample_in);
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, ledger.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // Offer one sample beat, optionally after an idle gap; valid stays high on return
  task automatic send_sample(input sample_t x);
    if (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every predicted sample has come out
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  task automatic write_reg(input logic [fdl_pkg::CFG_IDX_W-1:0] idx, input cfg_word_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    ledger.set_reg(idx, data);
  endtask

  task automatic apply_setting(input cfg_word_t m, input cfg_word_t dly, input cfg_word_t frac,
                               input cfg_word_t fb, input cfg_word_t dec, input cfg_word_t wet);
    write_reg(fdl_pkg::REG_MODE, m);
    write_reg(fdl_pkg::REG_DELAY, dly);
    write_reg(fdl_pkg::REG_FRACTION, frac);
    write_reg(fdl_pkg::REG_FEEDBACK, fb);
    write_reg(fdl_pkg::REG_DECAY, dec);
    write_reg(fdl_pkg::REG_WET, wet);
    cfg_we <= 1'b0;
    settings_used++;
    if (32'(dly[fdl_pkg::DELAY_W-1:0]) > widest_delay) begin
      widest_delay = 32'(dly[fdl_pkg::DELAY_W-1:0]);
    end
  endtask

  // Mostly short rings, some medium, a few near the top; junk above the field
  function automatic cfg_word_t pick_delay();
    logic [fdl_pkg::CFG_DATA_W-fdl_pkg::DELAY_W-1:0] junk;
    int unsigned                                     d;
    junk = (fdl_pkg::CFG_DATA_W - fdl_pkg::DELAY_W)'($urandom);
    case ($urandom_range(0, 9))
      7, 8:    d = $urandom_range(17, 400);
      9:       d = $urandom_range(3000, 4095);
      default: d = $urandom_range(0, 16);
    endcase
    return {junk, fdl_pkg::DELAY_W'(d)};
  endfunction

  function automatic cfg_word_t pick_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return cfg_word_t'(16'hFFFF);
      default: return cfg_word_t'($urandom);
    endcase
  endfunction

  function automatic cfg_word_t pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return fdl_pkg::Q16_ONE;
      2:       return '1;
      3:       return cfg_word_t'($urandom);
      default: return cfg_word_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'($urandom_range(0, 512)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Main sequence: reset, directed corners, then random register phases
  initial begin
    int unsigned sent;
    int unsigned phase_no;
    int unsigned count;
    ledger        = new();
    in_valid     <= 1'b0;
    sample_in    <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    hold_req      = 1'b0;
    steady        = 1'b0;
    holds_done    = 0;
    quiet_cycles  = 0;
    settings_used = 0;
    widest_delay  = 0;
    sent          = 0;
    phase_no      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values give a pass-through; unused indexes must change nothing
    write_reg(REG_UNUSED_LO, cfg_word_t'($urandom));
    write_reg(REG_UNUSED_HI, cfg_word_t'($urandom));
    cfg_we <= 1'b0;
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-16'sd1);
    quiesce();

    // one-sample delay, half fraction, all gains at their field maximum
    apply_setting(fdl_pkg::MODE_FEEDBACK, 1, 17'h08000, '1, '1, '1);
    repeat (3) send_sample(SAMPLE_MAX);
    repeat (3) send_sample(SAMPLE_MIN);
    quiesce();

    // allpass, full fraction, unit coefficient, wet gain at zero
    apply_setting(fdl_pkg::MODE_ALLPASS, 2, 17'h0FFFF, '0, fdl_pkg::Q16_ONE, '0);
    send_sample(16'sd12345);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    quiesce();

    // shrink to zero delay, so the ring holds a single slot
    apply_setting(fdl_pkg::MODE_ALLPASS, 0, 17'h01234, fdl_pkg::Q16_ONE,
                  fdl_pkg::Q16_HALF, fdl_pkg::Q16_ONE);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd100);
    send_sample(-16'sd100);
    quiesce();

    // longest ring the delay field can name
    apply_setting(fdl_pkg::MODE_FEEDBACK, 4095, 17'h0FFFF, fdl_pkg::Q16_HALF, '1, '0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd7);
    quiesce();

    // random phases, each under its own register setting
    while (sent < RANDOM_ITEMS) begin
      phase_no++;
      steady = (phase_no == 2);
      apply_setting(cfg_word_t'($urandom), pick_delay(), pick_fraction(),
                    pick_gain(), pick_gain(), pick_gain());
      count = $urandom_range(40, 150);
      for (int k = 0; k < count; k++) begin
        if (phase_no == 3 && k == 5) hold_req = 1'b1;
        if (phase_no == 4 && k == count / 2) quiesce();
        send_sample(pick_sample());
        sent++;
      end
      quiesce();
      steady = 1'b0;
    end

    // let any stray output surface before the verdict
    repeat (4 * LATENCY) @(posedge clk);
    $display("Checked %0d sample beats over %0d register settings, %0d in allpass mode.",
             ledger.beats, settings_used, ledger.allpass_beats);
    $display("Delays reached %0d samples; output held off for %0d long stretches.",
             widest_delay, holds_done);
    if (ledger.faults == 0 && ledger.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
